// ===== hdl/sbsh_pkg.sv =====
// Shared types, command/status structs and SHA-256 constants for the byte-stream hasher.
package sbsh_pkg;

    // Source of the byte that is shifted into the block buffer.
    typedef enum logic [1:0] {
        SEL_INPUT,
        SEL_MARK,
        SEL_ZERO,
        SEL_LENGTH
    } byte_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      push;
        byte_sel_t sel;
        logic      snap_len;
        logic      round_init;
        logic      round_step;
        logic [5:0] round_idx;
        logic      fold;
        logic      restart;
        logic [2:0] word_sel;
    } dp_cmd_t;

    // Status returned by the datapath.
    typedef struct packed {
        logic [5:0] fill_idx;
    } dp_status_t;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LAST_BYTE_IDX = 6'd63;
    localparam logic [5:0] LEN_START_IDX = 6'd56;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD     = 3'd7;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== hdl/sbsh_datapath.sv =====
// Datapath of the hasher: block buffer and message schedule, round unit, chaining words, length.
module sbsh_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  sbsh_pkg::dp_cmd_t  cmd,
    input  logic [7:0]         in_byte,
    output sbsh_pkg::dp_status_t status,
    output logic [31:0]        digest_word
);
    import sbsh_pkg::*;

    // The 512-bit buffer takes bytes at the bottom; during compression it is the
    // rolling 16-word schedule window with the current word at the top.
    logic [511:0] blk_reg;
    logic [31:0]  var_reg [8];
    logic [31:0]  chain_reg [8];
    logic [63:0]  byte_total_reg;
    logic [63:0]  len_reg;

    logic [7:0]   push_byte;
    logic [31:0]  w0, w1, w9, w14, new_w;
    logic [31:0]  t1, t2, ch, maj;
    logic [2:0]   len_sel;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // Byte selection for message, padding mark, zero fill and length bytes.
    assign len_sel = 3'(LAST_WORD - byte_total_reg[2:0]);
    always_comb begin
        unique case (cmd.sel)
            SEL_INPUT:  push_byte = in_byte;
            SEL_MARK:   push_byte = PAD_MARK;
            SEL_ZERO:   push_byte = 8'h00;
            SEL_LENGTH: push_byte = len_reg[{len_sel, 3'b000} +: 8];
            default:    push_byte = 8'h00;
        endcase
    end

    // Schedule taps and the next schedule word.
    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign new_w = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9 +
                   (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

    // One compression round.
    assign ch  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2]) ^
                 (var_reg[1] & var_reg[2]);
    assign t1  = var_reg[7] +
                 (rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25)) +
                 ch + ROUND_K[cmd.round_idx] + w0;
    assign t2  = (rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22)) + maj;

    // Buffer, working variables and length snapshot carry no reset.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            blk_reg <= {blk_reg[503:0], push_byte};
        end else if (cmd.round_step) begin
            blk_reg <= {blk_reg[479:0], new_w};
        end
        if (cmd.round_init) begin
            var_reg <= chain_reg;
        end else if (cmd.round_step) begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
        if (cmd.snap_len) begin
            len_reg <= {byte_total_reg[60:0], 3'b000};
        end
    end

    // Chaining words and byte count.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            chain_reg      <= HASH_INIT;
            byte_total_reg <= '0;
        end else begin
            if (cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
            if (cmd.push) begin
                byte_total_reg <= byte_total_reg + 64'd1;
            end
        end
    end

    assign status.fill_idx = byte_total_reg[5:0];
    assign digest_word     = chain_reg[cmd.word_sel];

endmodule

// ===== hdl/sbsh_ctrl.sv =====
// Controller of the hasher: sequences absorption, padding, compression rounds and digest output.
module sbsh_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_present,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_last,
    output logic [2:0]           word_idx,
    output sbsh_pkg::dp_cmd_t    cmd,
    input  sbsh_pkg::dp_status_t status
);
    import sbsh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LENGTH,
        ST_COMPRESS,
        ST_FOLD,
        ST_OUTPUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] word_reg, word_next;
    logic       eom_pend_reg, eom_pend_next;
    logic       pad_reg, pad_next;
    logic       len_done_reg, len_done_next;
    logic       block_full;

    assign block_full = (status.fill_idx == LAST_BYTE_IDX);

    // Next state and datapath commands.
    always_comb begin
        state_next    = state_reg;
        round_next    = round_reg;
        word_next     = word_reg;
        eom_pend_next = eom_pend_reg;
        pad_next      = pad_reg;
        len_done_next = len_done_reg;
        cmd           = '0;
        cmd.sel       = SEL_INPUT;
        cmd.round_idx = round_reg;
        cmd.word_sel  = word_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_present) begin
                        cmd.push = 1'b1;
                        if (block_full) begin
                            cmd.round_init = 1'b1;
                            eom_pend_next  = in_last;
                            state_next     = ST_COMPRESS;
                        end else if (in_last) begin
                            state_next = ST_MARK;
                        end
                    end else if (in_last) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                cmd.push      = 1'b1;
                cmd.sel       = SEL_MARK;
                cmd.snap_len  = 1'b1;
                pad_next      = 1'b1;
                eom_pend_next = 1'b0;
                if (block_full) begin
                    cmd.round_init = 1'b1;
                    state_next     = ST_COMPRESS;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (status.fill_idx == LEN_START_IDX) begin
                    state_next = ST_LENGTH;
                end else begin
                    cmd.push = 1'b1;
                    cmd.sel  = SEL_ZERO;
                    if (block_full) begin
                        cmd.round_init = 1'b1;
                        state_next     = ST_COMPRESS;
                    end
                end
            end
            ST_LENGTH: begin
                cmd.push = 1'b1;
                cmd.sel  = SEL_LENGTH;
                if (block_full) begin
                    cmd.round_init = 1'b1;
                    len_done_next  = 1'b1;
                    state_next     = ST_COMPRESS;
                end
            end
            ST_COMPRESS: begin
                cmd.round_step = 1'b1;
                round_next     = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                priority if (len_done_reg) begin
                    word_next  = '0;
                    state_next = ST_OUTPUT;
                end else if (eom_pend_reg) begin
                    state_next = ST_MARK;
                end else if (pad_reg) begin
                    state_next = ST_ZERO;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUTPUT: begin
                if (out_ready) begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == LAST_WORD) begin
                        cmd.restart   = 1'b1;
                        pad_next      = 1'b0;
                        len_done_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            round_reg    <= '0;
            word_reg     <= '0;
            eom_pend_reg <= 1'b0;
            pad_reg      <= 1'b0;
            len_done_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            word_reg     <= word_next;
            eom_pend_reg <= eom_pend_next;
            pad_reg      <= pad_next;
            len_done_reg <= len_done_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUTPUT);
    assign out_last  = (word_reg == LAST_WORD);
    assign word_idx  = word_reg;

`ifndef SYNTHESIS
    // Input and output sides are never open in the same cycle.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("input ready while digest is being delivered");

    // Compression runs all 64 rounds without a break.
    a_rounds_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMPRESS && round_reg != LAST_ROUND) |=> state_reg == ST_COMPRESS)
        else $error("compression left before the last round");

    // A compression starts only together with the byte that fills the block.
    a_init_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.round_init |-> (cmd.push && block_full))
        else $error("round start without a full block");

    // The final digest beat returns the block to idle with a fresh chain.
    a_last_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_ready && out_last) |=> (state_reg == ST_IDLE && !pad_reg))
        else $error("digest end did not restart the message");
`endif

endmodule

// ===== hdl/sha256_byte_stream_hasher_top.sv =====
// Top level of the SHA-256 byte-stream hasher: stream ports, controller and datapath.
//
// Message bytes enter one beat at a time on the s_ side; a beat with s_tlast high ends the
// message (with or without its own byte, as s_tuser says) and the digest leaves on the m_ side
// as eight beats, most significant word first, with m_tlast high on the eighth. Bytes
// that do not complete a 64-byte block are taken one per cycle. A byte that completes a block
// holds the input while the single round unit runs the rounds, one round per cycle, and the
// result is added into the chaining words. Finishing a message shifts in the padding (at most
// 72 bytes), runs one or two compressions and then waits for the eight digest beats to be
// taken; no new input is accepted until the last digest beat has gone.
module sha256_byte_stream_hasher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill above
    output logic        m_tlast    // last_word
);
    import sbsh_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [31:0] digest_word;
    logic [2:0]  word_idx;

    // Sequencing of bytes, rounds and digest beats.
    sbsh_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_present (s_tuser),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_last   (m_tlast),
        .word_idx   (word_idx),
        .cmd        (cmd),
        .status     (status)
    );

    // Buffer, schedule, round unit and chaining words.
    sbsh_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_byte     (s_tdata),
        .status      (status),
        .digest_word (digest_word)
    );

    assign m_tdata = {5'b00000, word_idx, digest_word};

endmodule
